// ===== src/ndtq_pkg.sv =====
package ndtq_pkg;
    localparam logic [63:0] QNAN_BITS = 64'h7fff_ffff_ffff_ffff;
    localparam logic [14:0] EXP_BIAS_ADJ = 15'd15360;
    localparam logic [14:0] SUB_EXP_BASE = 15'd15309;

    typedef struct packed {
        logic [63:0] bits;
        logic        overflow;
        logic        underflow;
    } ndtq_res_t;

    // Exact widening of a non-NaN double magnitude to binary128 {hi, lo}.
    function automatic logic [127:0] widen_mag(input logic [63:0] x);
        logic [10:0]  e;
        logic [51:0]  f;
        logic [5:0]   p;
        logic [111:0] fr;
        logic [127:0] w;
        e = x[62:52];
        f = x[51:0];
        p = 6'd0;
        fr = '0;
        w = '0;
        if (e == 11'h7ff) begin
            w = {1'b0, 15'h7fff, 112'd0};
        end else if (e != 11'd0) begin
            w = {1'b0, {4'd0, e} + EXP_BIAS_ADJ, f, 60'd0};
        end else if (f != 52'd0) begin
            for (int i = 0; i < 52; i++) begin
                if (f[i]) begin
                    p = 6'(i);
                end
            end
            // drop the leading one and align the rest to the top of the field
            fr = {f, 60'd0} << (7'd52 - {1'b0, p});
            w = {1'b0, {9'd0, p} + SUB_EXP_BASE, fr};
        end
        return w;
    endfunction
endpackage

// ===== src/ndtq_core.sv =====
module ndtq_core
    import ndtq_pkg::*;
(
    input  logic [63:0] x_bits,
    input  logic [63:0] y_hi,
    input  logic [63:0] y_lo,
    output ndtq_res_t   res
);
    logic         xneg, yneg, xnan, ynan, xzero, yzero, mag_lt, mag_eq;
    logic         step_up, equal;
    logic [127:0] xw;
    logic [127:0] yw;
    logic [63:0]  r;
    logic [30:0]  hx;

    assign xneg  = x_bits[63];
    assign yneg  = y_hi[63];
    assign xnan  = (x_bits[62:52] == 11'h7ff) && (x_bits[51:0] != 52'd0);
    assign ynan  = (y_hi[62:48] == 15'h7fff) && ((y_hi[47:0] != 48'd0) || (y_lo != 64'd0));
    assign xzero = x_bits[62:0] == 63'd0;
    assign yzero = (y_hi[62:0] == 63'd0) && (y_lo == 64'd0);
    assign xw    = widen_mag(x_bits);
    assign yw    = {1'b0, y_hi[62:0], y_lo};
    assign mag_lt = xw < yw;
    assign mag_eq = xw == yw;

    always_comb
    begin
        equal   = 1'b0;
        step_up = 1'b0;
        if (xzero && yzero) begin
            equal = 1'b1;
        end else if (xneg != yneg) begin
            step_up = xneg;
        end else if (mag_eq) begin
            equal = 1'b1;
        end else begin
            step_up = mag_lt ^ xneg;
        end
        if (xzero) begin
            r = {~step_up, 63'd1};
        end else if (step_up ^ xneg) begin
            r = x_bits + 64'd1;
        end else begin
            r = x_bits - 64'd1;
        end
        hx = r[62:32];
        res.bits      = r;
        res.overflow  = hx == 31'h7ff00000;
        res.underflow = hx < 31'h00100000;
        if (xnan || ynan) begin
            res = '{bits: QNAN_BITS, overflow: 1'b0, underflow: 1'b0};
        end else if (equal) begin
            res.bits      = xzero ? {y_hi[63], 63'd0} : x_bits;
            res.overflow  = 1'b0;
            res.underflow = 1'b0;
        end
    end
endmodule

// ===== src/next_double_toward_quad.sv =====
// An accepted input word reaches its result word through the input register,
// then the result register.
// Throughput: one word per cycle while out_stall is low; the single
// pass through the step logic between the two registers sets that figure.
// Reset: rst_n clears both valid flags asynchronously; payloads are not reset.
module next_double_toward_quad
    import ndtq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [63:0] x_bits,
    input  logic [63:0] y_hi,
    input  logic [63:0] y_lo,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] result_bits,
    output logic        overflow,
    output logic        underflow,
    output logic        inexact
);
    logic        iv_reg, ov_reg, adv;
    logic [63:0] x_reg, yh_reg, yl_reg;
    ndtq_res_t   res_next, res_reg;

    // advance when the result slot is empty or being taken
    assign adv      = !ov_reg || !out_stall;
    assign in_stall = iv_reg && !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            iv_reg <= 1'b0;
            ov_reg <= 1'b0;
        end else begin
            if (adv) begin
                ov_reg <= iv_reg;
            end
            if (!in_stall) begin
                iv_reg <= in_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid) begin
            x_reg  <= x_bits;
            yh_reg <= y_hi;
            yl_reg <= y_lo;
        end
        if (adv && iv_reg) begin
            res_reg <= res_next;
        end
    end

    ndtq_core u_core (
        .x_bits (x_reg),
        .y_hi   (yh_reg),
        .y_lo   (yl_reg),
        .res    (res_next)
    );

    assign out_valid   = ov_reg;
    assign result_bits = res_reg.bits;
    assign overflow    = res_reg.overflow;
    assign underflow   = res_reg.underflow;
    assign inexact     = res_reg.overflow | res_reg.underflow;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(result_bits))
        else $error("result word changed while stalled");
    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(overflow && underflow))
        else $error("overflow and underflow together");
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> iv_reg && ov_reg && out_stall)
        else $error("input stalled without cause");
endmodule
